// ===== sv/pclp_pkg.sv =====
package pclp_pkg;

  localparam int GAIN_W    = 16;
  localparam int PERIOD_W  = 16;
  localparam int TS_W      = 12;
  localparam int EFFORT_W  = 16;
  localparam int MAG_W     = 15;
  localparam int DUTY_W    = 16;
  localparam int MODE_W    = 3;
  localparam int PC_W      = 3;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam int MA_W      = GAIN_W + 1;
  localparam int MB_W      = 25;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int SPLIT     = 24;
  localparam int IPAD_W    = 2 * SPLIT;
  localparam int ACC_W     = 66;
  localparam int TERM_SHIFT = 50;
  localparam int MAG_SHIFT = 4;
  localparam int PCT_SHIFT = 8;

  localparam logic signed [ACC_W-1:0] TERM_MAX =
    {{(ACC_W-TERM_SHIFT-1){1'b0}}, 1'b1, {TERM_SHIFT{1'b0}}};
  localparam logic signed [ACC_W-1:0] TERM_MIN = -TERM_MAX;
  localparam logic [MAG_W-1:0] EFFORT_MAX = 15'd25600;

  localparam int DUTY_PW   = 23;
  localparam int RECIP_W   = 24;
  localparam int DIV_W     = DUTY_PW + RECIP_W;
  localparam int DIV_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

  localparam logic [GAIN_W-1:0]   KP_RESET     = 16'd410;
  localparam logic [GAIN_W-1:0]   KI_RESET     = 16'd82;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2399;
  localparam logic [TS_W-1:0]     TS_RESET     = 12'd100;

  localparam logic [1:0] REG_KP     = 2'd0;
  localparam logic [1:0] REG_KI     = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;
  localparam logic [1:0] REG_TS     = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE  = 3'd0,
    MODE_OPEN  = 3'd1,
    MODE_TEST  = 3'd2,
    MODE_HOLD  = 3'd3,
    MODE_TRACK = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PREP,
    OP_ACC_LOAD,
    OP_ACC_ADD,
    OP_ACC_CLAMP_ADD,
    OP_MAG,
    OP_FINISH
  } uop_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KI_HI,
    MUL_KI_LO,
    MUL_KP_ERR,
    MUL_DUTY
  } mul_sel_t;

  typedef enum logic {
    BR_NONE,
    BR_NOPI
  } br_t;

  typedef struct packed {
    uop_t            op;
    mul_sel_t        mul;
    br_t             br;
    logic [PC_W-1:0] target;
    logic            fin;
  } ucw_t;

  typedef struct packed {
    logic     load;
    logic     go;
    uop_t     op;
    mul_sel_t mul;
  } ctl_t;

  localparam logic [PC_W-1:0] PC_FINISH = 3'd7;

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      3'd0: w = '{OP_PREP,          MUL_NONE,   BR_NOPI, PC_FINISH, 1'b0};
      3'd1: w = '{OP_NOP,           MUL_KI_HI,  BR_NONE, '0,        1'b0};
      3'd2: w = '{OP_ACC_LOAD,      MUL_KI_LO,  BR_NONE, '0,        1'b0};
      3'd3: w = '{OP_ACC_ADD,       MUL_KP_ERR, BR_NONE, '0,        1'b0};
      3'd4: w = '{OP_ACC_CLAMP_ADD, MUL_NONE,   BR_NONE, '0,        1'b0};
      3'd5: w = '{OP_MAG,           MUL_NONE,   BR_NONE, '0,        1'b0};
      3'd6: w = '{OP_NOP,           MUL_DUTY,   BR_NONE, '0,        1'b0};
      3'd7: w = '{OP_FINISH,        MUL_NONE,   BR_NONE, '0,        1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/pclp_datapath.sv =====
module pclp_datapath
  import pclp_pkg::*;
#(
  parameter int CURRENT_WIDTH  = 16,
  parameter int INTEGRAL_WIDTH = 32,
  parameter int COUNT_WIDTH    = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ctl_t                            ctl,
  input  logic [MODE_W-1:0]               mode,
  input  logic signed [CURRENT_WIDTH-1:0] reference_ma,
  input  logic signed [CURRENT_WIDTH-1:0] measured_ma,
  input  logic                            clear_integral,
  input  logic [GAIN_W-1:0]               kp_gain,
  input  logic [GAIN_W-1:0]               ki_gain,
  input  logic [PERIOD_W-1:0]             pwm_period,
  input  logic [TS_W-1:0]                 test_samples,
  output logic                            pi_mode,
  output logic [DUTY_W-1:0]               duty_count,
  output logic                            duty_write,
  output logic                            direction,
  output logic signed [EFFORT_W-1:0]      effort,
  output logic [COUNT_WIDTH-1:0]          sample_index,
  output logic                            sample_valid,
  output logic                            test_done,
  output logic                            saturated
);

  localparam int EW   = CURRENT_WIDTH + 1;
  localparam int SW   = ((INTEGRAL_WIDTH > EW) ? INTEGRAL_WIDTH : EW) + 1;
  localparam int CMPW = ((COUNT_WIDTH + 1) > TS_W) ? (COUNT_WIDTH + 1) : TS_W;

  mode_t                             mode_r;
  logic signed [CURRENT_WIDTH-1:0]   ref_r;
  logic signed [CURRENT_WIDTH-1:0]   meas_r;
  logic signed [EW-1:0]              err_r;
  logic signed [INTEGRAL_WIDTH-1:0]  integ_r;
  logic [COUNT_WIDTH-1:0]            cnt_r;
  logic                              hdir_r;
  logic signed [EFFORT_W-1:0]        heff_r;
  logic [COUNT_WIDTH-1:0]            idx_r;
  logic                              valid_r;
  logic                              done_r;
  logic                              sat_r;
  logic signed [PROD_W-1:0]          prod_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic [MAG_W-1:0]                  mag_r;

  logic signed [EW-1:0]              err_c;
  logic signed [SW-1:0]              isum_c;
  logic                              isat_c;
  logic signed [INTEGRAL_WIDTH-1:0]  integ_c;
  logic [COUNT_WIDTH:0]              cnt_inc_c;
  logic                              run_end_c;
  logic signed [IPAD_W-1:0]          ipad_c;
  logic signed [MA_W-1:0]            mul_a_c;
  logic signed [MB_W-1:0]            mul_b_c;
  logic signed [PROD_W-1:0]          product_c;
  logic signed [ACC_W-1:0]           clamp_c;
  logic signed [ACC_W-1:0]           abs_c;
  logic [ACC_W-1:0]                  shr_c;
  logic                              mag_sat_c;
  logic [MAG_W-1:0]                  mag_c;
  logic [DIV_W-1:0]                  quot_c;

  assign pi_mode = (mode_r == MODE_TEST) || (mode_r == MODE_HOLD) || (mode_r == MODE_TRACK);

  always_comb begin
    err_c     = EW'(ref_r) - EW'(meas_r);
    isum_c    = SW'(integ_r) + SW'(err_c);
    isat_c    = ~((&isum_c[SW-1:INTEGRAL_WIDTH-1]) | ~(|isum_c[SW-1:INTEGRAL_WIDTH-1]));
    if (!isat_c) begin
      integ_c = isum_c[INTEGRAL_WIDTH-1:0];
    end else if (isum_c[SW-1]) begin
      integ_c = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
    end else begin
      integ_c = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    end
    cnt_inc_c = {1'b0, cnt_r} + 1'b1;
    run_end_c = CMPW'(cnt_inc_c) >= CMPW'(test_samples);
  end

  always_comb begin
    ipad_c = IPAD_W'(integ_r);
    mul_a_c = '0;
    mul_b_c = '0;
    case (ctl.mul)
      MUL_KI_HI: begin
        mul_a_c = {1'b0, ki_gain};
        mul_b_c = MB_W'(signed'(ipad_c[IPAD_W-1:SPLIT]));
      end
      MUL_KI_LO: begin
        mul_a_c = {1'b0, ki_gain};
        mul_b_c = {1'b0, ipad_c[SPLIT-1:0]};
      end
      MUL_KP_ERR: begin
        mul_a_c = {1'b0, kp_gain};
        mul_b_c = MB_W'(err_r);
      end
      MUL_DUTY: begin
        mul_a_c = {1'b0, pwm_period};
        mul_b_c = MB_W'(mag_r[MAG_W-1:PCT_SHIFT]);
      end
      default: begin
        mul_a_c = '0;
        mul_b_c = '0;
      end
    endcase
    product_c = mul_a_c * mul_b_c;
  end

  always_comb begin
    if (acc_r > TERM_MAX) begin
      clamp_c = TERM_MAX;
    end else if (acc_r < TERM_MIN) begin
      clamp_c = TERM_MIN;
    end else begin
      clamp_c = acc_r;
    end
    abs_c     = acc_r[ACC_W-1] ? -acc_r : acc_r;
    shr_c     = abs_c >> MAG_SHIFT;
    mag_sat_c = shr_c > ACC_W'(EFFORT_MAX);
    mag_c     = mag_sat_c ? EFFORT_MAX : shr_c[MAG_W-1:0];
    quot_c    = DIV_W'(prod_r[DUTY_PW-1:0]) * DIV_W'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mode_r <= mode_t'(mode);
      ref_r  <= reference_ma;
      meas_r <= measured_ma;
    end
    if (ctl.go && ctl.mul != MUL_NONE) begin
      prod_r <= product_c;
    end
    if (ctl.go) begin
      case (ctl.op)
        OP_PREP:          err_r <= err_c;
        OP_ACC_LOAD:      acc_r <= ACC_W'(prod_r) <<< SPLIT;
        OP_ACC_ADD:       acc_r <= acc_r + ACC_W'(prod_r);
        OP_ACC_CLAMP_ADD: acc_r <= clamp_c + ACC_W'(prod_r);
        OP_MAG:           mag_r <= mag_c;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      cnt_r   <= '0;
      hdir_r  <= 1'b1;
      heff_r  <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
      done_r  <= 1'b0;
      sat_r   <= 1'b0;
    end else if (ctl.load) begin
      if (clear_integral) begin
        integ_r <= '0;
      end
      idx_r   <= '0;
      valid_r <= 1'b0;
      done_r  <= 1'b0;
      sat_r   <= 1'b0;
    end else if (ctl.go) begin
      case (ctl.op)
        OP_PREP: begin
          if (pi_mode) begin
            integ_r <= integ_c;
            sat_r   <= isat_c;
          end
          if (mode_r == MODE_TEST) begin
            idx_r   <= cnt_r;
            valid_r <= 1'b1;
            done_r  <= run_end_c;
            cnt_r   <= run_end_c ? '0 : cnt_inc_c[COUNT_WIDTH-1:0];
          end
        end
        OP_MAG: begin
          hdir_r <= ~acc_r[ACC_W-1];
          heff_r <= acc_r[ACC_W-1] ? -EFFORT_W'(mag_c) : EFFORT_W'(mag_c);
          if (mag_sat_c) begin
            sat_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign duty_count   = pi_mode ? quot_c[DIV_SHIFT+DUTY_W-1:DIV_SHIFT] : '0;
  assign duty_write   = pi_mode || (mode_r == MODE_IDLE);
  assign direction    = hdir_r;
  assign effort       = heff_r;
  assign sample_index = idx_r;
  assign sample_valid = valid_r;
  assign test_done    = done_r;
  assign saturated    = sat_r;

endmodule

// ===== sv/pi_current_loop_pwm.sv =====
// channel | dir | beat fields (low bit first)
// in_     | in  | tuser: mode; tdata: reference_ma, measured_ma, clear_integral
// out_    | out | tdata: duty_count, duty_write, direction, effort, sample_index,
//         |     |        sample_valid, test_done, saturated
// cfg_    | in  | APB registers kp_gain, ki_gain, pwm_period, test_samples at 4*i
//
// A PI tick runs each microcode step from PREP to FINISH; idle and open PWM ticks
// branch from PREP to FINISH. The program steps one shared 17x25 multiplier.
// Synchronous active-low reset loads register defaults and clears the integral.
// The result sits in an output register; a stalled result holds the last step.
module pi_current_loop_pwm
  import pclp_pkg::*;
#(
  parameter int CURRENT_WIDTH  = 16,
  parameter int INTEGRAL_WIDTH = 32,
  parameter int COUNT_WIDTH    = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // reference_ma, measured_ma, clear_integral
  input  logic [((2*CURRENT_WIDTH+1+7)/8)*8-1:0] in_tdata,
  // mode
  input  logic [MODE_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // duty_count, duty_write, direction, effort, sample_index,
  // sample_valid, test_done, saturated
  output logic [((COUNT_WIDTH+37+7)/8)*8-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_AW-1:0]     cfg_paddr,
  input  logic [APB_DW-1:0]     cfg_pwdata,
  output logic [APB_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  localparam int OUT_W = ((COUNT_WIDTH + 37 + 7) / 8) * 8;

  logic [GAIN_W-1:0]   kp_r;
  logic [GAIN_W-1:0]   ki_r;
  logic [PERIOD_W-1:0] period_r;
  logic [TS_W-1:0]     ts_r;

  logic                busy_r;
  logic                busy_nxt;
  logic [PC_W-1:0]     pc_r;
  logic [PC_W-1:0]     pc_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r;

  ucw_t                cw;
  ctl_t                ctl;
  logic                accept;
  logic                advance;
  logic                finish;
  logic                cfg_wr;

  logic                pi_mode;
  logic [DUTY_W-1:0]   duty_count;
  logic                duty_write;
  logic                direction;
  logic signed [EFFORT_W-1:0] effort;
  logic [COUNT_WIDTH-1:0] sample_index;
  logic                sample_valid;
  logic                test_done;
  logic                saturated;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= KP_RESET;
      ki_r     <= KI_RESET;
      period_r <= PERIOD_RESET;
      ts_r     <= TS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_KP:     kp_r     <= cfg_pwdata[GAIN_W-1:0];
        REG_KI:     ki_r     <= cfg_pwdata[GAIN_W-1:0];
        REG_PERIOD: period_r <= cfg_pwdata[PERIOD_W-1:0];
        REG_TS:     ts_r     <= cfg_pwdata[TS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_KP:     cfg_prdata = APB_DW'(kp_r);
      REG_KI:     cfg_prdata = APB_DW'(ki_r);
      REG_PERIOD: cfg_prdata = APB_DW'(period_r);
      REG_TS:     cfg_prdata = APB_DW'(ts_r);
    endcase
  end

  assign in_tready = ~busy_r;
  assign accept    = in_tvalid && in_tready;
  assign cw        = ucode(pc_r);
  assign advance   = busy_r && (!cw.fin || !out_valid_r || out_tready);
  assign finish    = advance && cw.fin;

  always_comb begin
    ctl.load = accept;
    ctl.go   = advance;
    ctl.op   = cw.op;
    ctl.mul  = cw.mul;
  end

  always_comb begin
    pc_nxt = pc_r;
    if (accept) begin
      pc_nxt = '0;
    end else if (advance) begin
      if (cw.fin) begin
        pc_nxt = '0;
      end else if (cw.br == BR_NOPI && !pi_mode) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= OUT_W'({saturated, test_done, sample_valid, sample_index,
                            effort, direction, duty_write, duty_count});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  pclp_datapath #(
    .CURRENT_WIDTH  (CURRENT_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .mode           (in_tuser),
    .reference_ma   (in_tdata[CURRENT_WIDTH-1:0]),
    .measured_ma    (in_tdata[2*CURRENT_WIDTH-1:CURRENT_WIDTH]),
    .clear_integral (in_tdata[2*CURRENT_WIDTH]),
    .kp_gain        (kp_r),
    .ki_gain        (ki_r),
    .pwm_period     (period_r),
    .test_samples   (ts_r),
    .pi_mode        (pi_mode),
    .duty_count     (duty_count),
    .duty_write     (duty_write),
    .direction      (direction),
    .effort         (effort),
    .sample_index   (sample_index),
    .sample_valid   (sample_valid),
    .test_done      (test_done),
    .saturated      (saturated)
  );

endmodule
